@@ sv/lru_block_cache_tags_macros.svh @@
// Assertion helpers used by the file that checks the tag logic.
`ifndef LRU_BLOCK_CACHE_TAGS_MACROS_SVH
`define LRU_BLOCK_CACHE_TAGS_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LBCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LBCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lbct_pkg.sv @@
package lbct_pkg;

  localparam int MaxSlots = 16;
  localparam int SlotW    = $clog2(MaxSlots);
  localparam int CntW     = $clog2(MaxSlots + 1);
  localparam int BlockW   = 20;
  localparam int CfgW     = 5;
  localparam int SlotIdxW = 4;

  // Active slot count: the register value clamped to 2..MaxSlots.
  function automatic logic [CntW-1:0] clamp_count(input logic [CfgW-1:0] v);
    logic [CntW-1:0] n;
    if (int'(v) < 2) begin
      n = CntW'(2);
    end else if (int'(v) > MaxSlots) begin
      n = CntW'(MaxSlots);
    end else begin
      n = CntW'(v);
    end
    return n;
  endfunction

  // Recency rank of a slot after an open: slot 0 newest, slot 1 oldest.
  function automatic logic [SlotW-1:0] open_rank(input int i, input logic [CntW-1:0] n);
    logic [SlotW-1:0] r;
    if (i == 0 || i >= int'(n)) begin
      r = '0;
    end else begin
      r = SlotW'(int'(n) - i);
    end
    return r;
  endfunction

endpackage

@@ sv/lbct_req_if.sv @@
interface lbct_req_if;
  import lbct_pkg::*;

  logic              valid;
  logic              ready;
  logic [BlockW-1:0] block_number;

  modport source (output valid, output block_number, input ready);
  modport sink   (input valid, input block_number, output ready);
endinterface

@@ sv/lbct_rsp_if.sv @@
interface lbct_rsp_if;
  import lbct_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic [SlotIdxW-1:0] slot_index;
  logic                evicted_valid;
  logic [BlockW-1:0]   evicted_block;

  modport source (output valid, output hit, output slot_index, output evicted_valid,
                  output evicted_block, input ready);
  modport sink   (input valid, input hit, input slot_index, input evicted_valid,
                  input evicted_block, output ready);
endinterface

@@ sv/lru_block_cache_tags.sv @@
// Channel   Dir   Payload                                            Handshake
// req_i     in    block_number                                       valid/ready
// rsp_o     out   hit, slot_index, evicted_valid, evicted_block      valid/ready
// cfg       in    cfg_wdata_i (slots_in_use)                         cfg_we_i
//
// On a miss the search pass visits every one of the N active slots; a hit ends
// the search pass early. Search and rank update each step through the
// slot table one entry per cycle with a single compare unit. req_i.ready is high
// only while the sequencer is idle; a finished result waits in S_DONE while the
// output register is still full. Reset and any configuration write empty every
// slot and restore slot 1 as the oldest.
module lru_block_cache_tags (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lbct_pkg::CfgW-1:0]  cfg_wdata_i,
  lbct_req_if.sink                   req_i,
  lbct_rsp_if.source                 rsp_o
);
  import lbct_pkg::*;

  `include "lru_block_cache_tags_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_UPDATE = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]   n_q;
  logic              valid_q [MaxSlots];
  logic [BlockW-1:0] blk_q   [MaxSlots];
  logic [SlotW-1:0]  rank_q  [MaxSlots];

  logic [BlockW-1:0] req_blk_q, req_blk_d;
  logic [SlotW-1:0]  idx_q, idx_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [SlotW-1:0]  age_q, age_d;
  logic [SlotW-1:0]  vic_q, vic_d;
  logic              vic_found_q, vic_found_d;
  logic              hit_q, hit_d;
  logic              ev_valid_q, ev_valid_d;
  logic [BlockW-1:0] ev_blk_q, ev_blk_d;

  logic                rsp_valid_q, rsp_valid_d;
  logic                out_hit_q, out_hit_d;
  logic [SlotIdxW-1:0] out_slot_q, out_slot_d;
  logic                out_ev_valid_q, out_ev_valid_d;
  logic [BlockW-1:0]   out_ev_blk_q, out_ev_blk_d;

  logic              tag_we;
  logic [SlotW-1:0]  tag_waddr;
  logic              rank_we;
  logic [SlotW-1:0]  rank_wdata;

  logic              cur_valid;
  logic [BlockW-1:0] cur_blk;
  logic [SlotW-1:0]  cur_rank;
  logic [SlotW-1:0]  top_rank;
  logic              last;
  logic              match;
  logic              vic_now;
  logic [CntW-1:0]   cfg_n;

  // The single scan port: one slot is looked at per cycle.
  assign cur_valid = valid_q[idx_q];
  assign cur_blk   = blk_q[idx_q];
  assign cur_rank  = rank_q[idx_q];
  assign top_rank  = SlotW'(n_q - CntW'(1));
  assign last      = (CntW'(idx_q) == (n_q - CntW'(1)));
  assign match     = cur_valid && (cur_blk == req_blk_q);
  assign vic_now   = !vic_found_q && (cur_rank == top_rank);
  assign cfg_n     = clamp_count(cfg_wdata_i);

  always_comb begin
    state_d        = state_q;
    req_blk_d      = req_blk_q;
    idx_d          = idx_q;
    slot_d         = slot_q;
    age_d          = age_q;
    vic_d          = vic_q;
    vic_found_d    = vic_found_q;
    hit_d          = hit_q;
    ev_valid_d     = ev_valid_q;
    ev_blk_d       = ev_blk_q;
    rsp_valid_d    = rsp_valid_q;
    out_hit_d      = out_hit_q;
    out_slot_d     = out_slot_q;
    out_ev_valid_d = out_ev_valid_q;
    out_ev_blk_d   = out_ev_blk_q;
    tag_we         = 1'b0;
    tag_waddr      = vic_q;
    rank_we        = 1'b0;
    rank_wdata     = cur_rank;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_blk_d   = req_i.block_number;
          idx_d       = '0;
          vic_d       = '0;
          vic_found_d = 1'b0;
          hit_d       = 1'b0;
          ev_valid_d  = 1'b0;
          ev_blk_d    = '0;
          state_d     = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (match) begin
          // A hit evicts nothing, even if the oldest slot was already seen.
          slot_d     = idx_q;
          hit_d      = 1'b1;
          age_d      = cur_rank;
          ev_valid_d = 1'b0;
          ev_blk_d   = '0;
          idx_d      = '0;
          state_d    = S_UPDATE;
        end else begin
          // Remember the oldest slot and what it holds while scanning for a hit.
          if (vic_now) begin
            vic_d       = idx_q;
            vic_found_d = 1'b1;
            ev_valid_d  = cur_valid;
            ev_blk_d    = cur_valid ? cur_blk : '0;
          end
          if (last) begin
            // Miss: the oldest slot is retagged and its age is always the top rank.
            tag_we    = 1'b1;
            tag_waddr = vic_now ? idx_q : vic_q;
            slot_d    = tag_waddr;
            age_d     = top_rank;
            idx_d     = '0;
            state_d   = S_UPDATE;
          end else begin
            idx_d = idx_q + SlotW'(1);
          end
        end
      end
      S_UPDATE: begin
        rank_we = 1'b1;
        if (idx_q == slot_q) begin
          rank_wdata = '0;
        end else if (cur_rank < age_q) begin
          rank_wdata = cur_rank + SlotW'(1);
        end
        if (last) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + SlotW'(1);
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d    = 1'b1;
          out_hit_d      = hit_q;
          out_slot_d     = SlotIdxW'(slot_q);
          out_ev_valid_d = ev_valid_q;
          out_ev_blk_d   = ev_blk_q;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      slot_q      <= '0;
      age_q       <= '0;
      vic_q       <= '0;
      vic_found_q <= 1'b0;
      hit_q       <= 1'b0;
      ev_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      slot_q      <= slot_d;
      age_q       <= age_d;
      vic_q       <= vic_d;
      vic_found_q <= vic_found_d;
      hit_q       <= hit_d;
      ev_valid_q  <= ev_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_blk_q      <= req_blk_d;
    ev_blk_q       <= ev_blk_d;
    out_hit_q      <= out_hit_d;
    out_slot_q     <= out_slot_d;
    out_ev_valid_q <= out_ev_valid_d;
    out_ev_blk_q   <= out_ev_blk_d;
  end

  // Slot count, valid bits and ranks: reset and configuration writes reopen the store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= CntW'(MaxSlots);
      for (int i = 0; i < MaxSlots; i++) begin
        valid_q[i] <= 1'b0;
        rank_q[i]  <= open_rank(i, CntW'(MaxSlots));
      end
    end else if (cfg_we_i) begin
      n_q <= cfg_n;
      for (int i = 0; i < MaxSlots; i++) begin
        valid_q[i] <= 1'b0;
        rank_q[i]  <= open_rank(i, cfg_n);
      end
    end else begin
      if (tag_we) begin
        valid_q[tag_waddr] <= 1'b1;
      end
      if (rank_we) begin
        rank_q[idx_q] <= rank_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      blk_q[tag_waddr] <= req_blk_q;
    end
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.hit           = out_hit_q;
  assign rsp_o.slot_index    = out_slot_q;
  assign rsp_o.evicted_valid = out_ev_valid_q;
  assign rsp_o.evicted_block = out_ev_blk_q;

  `LBCT_ASSERT_NEXT(a_accept_starts_search, req_i.valid && req_i.ready,
                    state_q == S_SEARCH, "accepted item did not start a search")
  `LBCT_ASSERT_NOW(a_scan_in_range, state_q == S_SEARCH || state_q == S_UPDATE,
                   CntW'(idx_q) < n_q, "scan index beyond active slots")
  `LBCT_ASSERT_NOW(a_hit_no_evict, rsp_o.valid && rsp_o.hit, !rsp_o.evicted_valid,
                   "hit reported an eviction")
  `LBCT_ASSERT_NEXT(a_miss_fills_slot, state_q == S_SEARCH && !match && last,
                    valid_q[slot_q] && blk_q[slot_q] == req_blk_q,
                    "missed block not written to its slot")

endmodule
